[hw/rtl/sahh_pkg.sv]
// sahh_pkg: shared constants and action codes of the address hit histogram
// no dependencies; imported by every module of the block
`default_nettype none

package sahh_pkg;

  localparam int BIN_COUNT_DEF = 293;
  localparam int ADDR_W        = 32;
  localparam int HITS_W        = 16;
  localparam int ACTION_W      = 2;

  // the bin index is reduced one address byte per cycle
  localparam int DIGIT_W       = 8;
  localparam int DIGIT_CNT     = ADDR_W / DIGIT_W;
  localparam int DIGIT_CNT_W   = $clog2(DIGIT_CNT);

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

endpackage

`default_nettype wire

[hw/rtl/sahh_ram.sv]
// sahh_ram: generic single write port, single read port ram with registered read
// depends on sahh_pkg for its parameter defaults; no other modules
`default_nettype none

module sahh_ram
  import sahh_pkg::*;
#(
  parameter int WIDTH = HITS_W,
  parameter int DEPTH = BIN_COUNT_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/sampled_address_hit_histogram_top.sv]
// sampled_address_hit_histogram_top: sampling profiler table of per-bin hit counts
// depends on sahh_pkg and sahh_ram (one for hit counts, one for bin addresses)
//
// usage
//   input channel in_valid/in_ready carries in_action and in_sample_addr
//   result channel out_valid/out_ready carries out_top_addr, out_top_hits, out_found
//   one item is in work at a time; in_ready is high only while the block is idle
//   sample: bin = address mod BIN_COUNT, found one address byte per cycle,
//     then one read and one write of the count ram
//   clear: one count ram entry zeroed per cycle
//   query: one bin read per cycle through the ram read port; a query is the
//     only action that yields a result
//   action code 3 is taken and ignored
//   the result sits in an output register; the block keeps taking samples and
//     clears while it waits; a later query holds at its end until the
//     receiver takes the earlier result
//   reset runs the same zeroing pass as a clear, with in_ready low;
//     bin addresses are not cleared
`default_nettype none

module sampled_address_hit_histogram_top
  import sahh_pkg::*;
#(
  parameter int BIN_COUNT = BIN_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [ACTION_W-1:0] in_action,
  input  wire logic [ADDR_W-1:0]   in_sample_addr,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [ADDR_W-1:0]   out_top_addr,
  output logic      [HITS_W-1:0]   out_top_hits,
  output logic                     out_found
);

  localparam int IW = $clog2(BIN_COUNT);
  localparam logic [IW:0]   NBIN     = (IW + 1)'(BIN_COUNT);
  localparam logic [IW-1:0] LAST_IDX = IW'(BIN_COUNT - 1);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_MOD   = 7'b0000100,
    ST_READ  = 7'b0001000,
    ST_WRITE = 7'b0010000,
    ST_SCAN  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic [IW-1:0]          rem_r, rem_nxt;
  logic [ADDR_W-1:0]      shf_r, shf_nxt;
  logic [ADDR_W-1:0]      addr_r, addr_nxt;
  logic [DIGIT_CNT_W-1:0] dig_r, dig_nxt;
  logic                   iss_done_r, iss_done_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [HITS_W-1:0]      best_r, best_nxt;
  logic [ADDR_W-1:0]      best_addr_r, best_addr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]      out_addr_r, out_addr_nxt;
  logic [HITS_W-1:0]      out_hits_r, out_hits_nxt;
  logic                   out_found_r, out_found_nxt;

  logic [IW-1:0]          rem_step;
  logic                   in_xfer;
  logic                   out_load;

  logic                   cnt_we;
  logic [IW-1:0]          cnt_waddr;
  logic [HITS_W-1:0]      cnt_wdata;
  logic [HITS_W-1:0]      cnt_rdata;
  logic                   adr_we;
  logic [ADDR_W-1:0]      adr_rdata;
  logic [IW-1:0]          raddr;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign out_valid    = out_valid_r;
  assign out_top_addr = out_addr_r;
  assign out_top_hits = out_hits_r;
  assign out_found    = out_found_r;

  // one address byte folded into the running remainder
  always_comb begin
    logic [IW:0]   t;
    logic [IW-1:0] acc;
    acc = rem_r;
    t   = '0;
    for (int b = 0; b < DIGIT_W; b++) begin
      t = {acc, shf_r[ADDR_W-1-b]};
      if (t >= NBIN) begin
        t = t - NBIN;
      end
      acc = t[IW-1:0];
    end
    rem_step = acc;
  end

  assign raddr     = (state_r == ST_SCAN) ? idx_r : rem_r;
  assign cnt_we    = (state_r == ST_CLEAR) || (state_r == ST_WRITE);
  assign cnt_waddr = (state_r == ST_CLEAR) ? idx_r : rem_r;
  assign cnt_wdata = (state_r == ST_CLEAR) ? '0 : cnt_rdata + HITS_W'(1);
  assign adr_we    = (state_r == ST_WRITE);

  sahh_ram #(
    .WIDTH (HITS_W),
    .DEPTH (BIN_COUNT)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (raddr),
    .rdata (cnt_rdata)
  );

  sahh_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (BIN_COUNT)
  ) u_adr_ram (
    .clk   (clk),
    .we    (adr_we),
    .waddr (rem_r),
    .wdata (addr_r),
    .raddr (raddr),
    .rdata (adr_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    shf_nxt       = shf_r;
    addr_nxt      = addr_r;
    dig_nxt       = dig_r;
    iss_done_nxt  = iss_done_r;
    rd_vld_nxt    = 1'b0;
    best_nxt      = best_r;
    best_addr_nxt = best_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_addr_nxt  = out_addr_r;
    out_hits_nxt  = out_hits_r;
    out_found_nxt = out_found_r;

    unique case (state_r)
      ST_CLEAR: begin
        idx_nxt = idx_r + IW'(1);
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (action_t'(in_action))
            ACT_CLEAR: begin
              idx_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            ACT_SAMPLE: begin
              addr_nxt  = in_sample_addr;
              shf_nxt   = in_sample_addr;
              rem_nxt   = '0;
              dig_nxt   = '0;
              state_nxt = ST_MOD;
            end
            ACT_QUERY: begin
              idx_nxt       = '0;
              iss_done_nxt  = 1'b0;
              best_nxt      = '0;
              best_addr_nxt = '0;
              state_nxt     = ST_SCAN;
            end
            ACT_NONE: begin
              state_nxt = ST_IDLE;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MOD: begin
        rem_nxt = rem_step;
        shf_nxt = shf_r << DIGIT_W;
        dig_nxt = dig_r + DIGIT_CNT_W'(1);
        if (dig_r == DIGIT_CNT_W'(DIGIT_CNT - 1)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (!iss_done_r) begin
          rd_vld_nxt = 1'b1;
          idx_nxt    = idx_r + IW'(1);
          if (idx_r == LAST_IDX) begin
            iss_done_nxt = 1'b1;
          end
        end
        if (rd_vld_r && (cnt_rdata > best_r)) begin
          best_nxt      = cnt_rdata;
          best_addr_nxt = adr_rdata;
        end
        if (iss_done_r && !rd_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = best_addr_r;
          out_hits_nxt  = best_r;
          out_found_nxt = (best_r != '0);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      dig_r       <= '0;
      iss_done_r  <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      dig_r       <= dig_nxt;
      iss_done_r  <= iss_done_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    shf_r       <= shf_nxt;
    addr_r      <= addr_nxt;
    best_r      <= best_nxt;
    best_addr_r <= best_addr_nxt;
    out_addr_r  <= out_addr_nxt;
    out_hits_r  <= out_hits_nxt;
    out_found_r <= out_found_nxt;
  end

`ifndef SYNTHESIS
  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared outside the end of a query");

  a_found_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_found_r == (out_hits_r != '0)))
    else $error("found flag disagrees with hit count");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !rd_vld_r)
    else $error("scan read still in flight while idle");

  a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> ({1'b0, rem_r} < NBIN))
    else $error("bin index out of range");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
// tb: self-checking bench for sampled_address_hit_histogram_top, directed and random phases
// depends on sahh_pkg and the block's rtl; predicts query results from a local copy of the table
`timescale 1ns / 100ps

module tb;
  import sahh_pkg::*;

  localparam int NBINS        = BIN_COUNT_DEF;
  localparam int RAND_ITEMS   = 1400;
  localparam int HOLD_CYCLES  = 1500;
  localparam int HOLD_AT      = 40;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 2 * (BIN_COUNT_DEF + 8);
  localparam int CALM_FROM    = 30000;
  localparam int CALM_TO      = 60000;

  typedef struct {
    action_t           act;
    logic [ADDR_W-1:0] addr;
  } stim_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [HITS_W-1:0] hits;
    logic              found;
  } top_bin_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [ACTION_W-1:0] in_action;
  logic [ADDR_W-1:0]   in_sample_addr;
  logic                out_valid;
  logic                out_ready;
  logic [ADDR_W-1:0]   out_top_addr;
  logic [HITS_W-1:0]   out_top_hits;
  logic                out_found;

  stim_t             stim_q[$];
  top_bin_t          top_bin_q[$];
  logic [HITS_W-1:0] bin_hits [NBINS];
  logic [ADDR_W-1:0] bin_addr [NBINS];

  stim_t    drv_item;
  top_bin_t want_top;
  logic     in_took;
  logic     hold_done;
  int       hold_left;
  int       results_seen;
  int       err_cnt;
  int       cyc;
  int       stall_cnt;
  logic     calm;

  sampled_address_hit_histogram_top #(
    .BIN_COUNT(BIN_COUNT_DEF)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_sample_addr(in_sample_addr),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_top_addr  (out_top_addr),
    .out_top_hits  (out_top_hits),
    .out_found     (out_found)
  );

  always #5 clk = ~clk;

  assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  task automatic histogram_apply(action_t act, logic [ADDR_W-1:0] addr);
    int       b;
    int       i;
    top_bin_t t;
    case (act)
      ACT_CLEAR: begin
        for (i = 0; i < NBINS; i++) bin_hits[i] = '0;
      end
      ACT_SAMPLE: begin
        b = int'(addr % NBINS);
        bin_hits[b] = bin_hits[b] + 1'b1;
        bin_addr[b] = addr;
      end
      ACT_QUERY: begin
        t.addr = '0;
        t.hits = '0;
        for (i = 0; i < NBINS; i++) begin
          if (bin_hits[i] > t.hits) begin
            t.hits = bin_hits[i];
            t.addr = bin_addr[i];
          end
        end
        t.found = (t.hits != '0);
        top_bin_q.push_back(t);
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
    err_cnt++;
  endtask

  task automatic push_item(action_t act, logic [ADDR_W-1:0] addr);
    stim_t s;
    s.act  = act;
    s.addr = addr;
    stim_q.push_back(s);
  endtask

  // any address that lands in bin b
  function automatic logic [ADDR_W-1:0] addr_in_bin(int b);
    logic [ADDR_W-1:0] k;
    k = $urandom_range(0, 14000000);
    return ADDR_W'(b) + ADDR_W'(NBINS) * k;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    int r;
    int h;
    r = $urandom_range(0, 99);
    h = $urandom_range(0, 11);
    if (r < 50) return addr_in_bin((h < 6) ? h : NBINS - 12 + h);
    if (r < 75) return $urandom;
    if (r < 88) begin
      case (h % 6)
        0:       return '0;
        1:       return '1;
        2:       return 32'hAAAA_AAAA;
        3:       return 32'h5555_5555;
        4:       return 32'h8000_0000;
        default: return 32'h0000_0001;
      endcase
    end
    return addr_in_bin($urandom_range(0, NBINS - 1));
  endfunction

  task automatic fill_stimulus();
    int i;
    int r;
    // directed: empty table, shared bin, ties, ignored code, clear
    push_item(ACT_QUERY,  $urandom);
    push_item(ACT_SAMPLE, 32'h0000_0000);
    push_item(ACT_SAMPLE, 32'hFFFF_FFFF);
    push_item(ACT_SAMPLE, 32'd293);
    push_item(ACT_QUERY,  $urandom);
    push_item(ACT_NONE,   $urandom);
    push_item(ACT_QUERY,  '1);
    push_item(ACT_CLEAR,  '1);
    push_item(ACT_QUERY,  '0);
    push_item(ACT_SAMPLE, 32'd7 + 32'd293 * 32'd5);
    push_item(ACT_SAMPLE, 32'd3 + 32'd293 * 32'd9);
    push_item(ACT_QUERY,  $urandom);
    push_item(ACT_SAMPLE, 32'd7);
    push_item(ACT_QUERY,  $urandom);
    push_item(ACT_SAMPLE, 32'hAAAA_AAAA);
    push_item(ACT_SAMPLE, 32'h5555_5555);
    push_item(ACT_SAMPLE, 32'h8000_0000);
    push_item(ACT_SAMPLE, 32'h7FFF_FFFF);
    push_item(ACT_NONE,   '1);
    push_item(ACT_QUERY,  $urandom);
    push_item(ACT_CLEAR,  $urandom);
    push_item(ACT_NONE,   '0);
    push_item(ACT_QUERY,  $urandom);

    for (i = 0; i < RAND_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60)      push_item(ACT_SAMPLE, pick_addr());
      else if (r < 85) push_item(ACT_QUERY,  $urandom);
      else if (r < 95) push_item(ACT_CLEAR,  $urandom);
      else             push_item(ACT_NONE,   $urandom);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if ((stim_q.size() != 0) && (calm || ($urandom_range(0, 99) >= 15))) begin
        drv_item = stim_q.pop_front();
        in_action      <= drv_item.act;
        in_sample_addr <= drv_item.addr;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && (results_seen == HOLD_AT)) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  // monitor
  always @(posedge clk) begin
    cyc     <= cyc + 1;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (top_bin_q.size() == 0) begin
          flag_mismatch("unexpected result, top_addr", out_top_addr, '0);
        end else begin
          want_top = top_bin_q.pop_front();
          if (out_top_addr !== want_top.addr)
            flag_mismatch("top_addr", out_top_addr, want_top.addr);
          if (out_top_hits !== want_top.hits)
            flag_mismatch("top_hits", out_top_hits, want_top.hits);
          if (out_found !== want_top.found)
            flag_mismatch("found", out_found, want_top.found);
        end
        results_seen <= results_seen + 1;
      end
      if (in_valid && in_ready)
        histogram_apply(action_t'(in_action), in_sample_addr);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_NONE;
    in_sample_addr = '0;
    out_ready      = 1'b0;
    in_took        = 1'b0;
    hold_done      = 1'b0;
    hold_left      = 0;
    results_seen   = 0;
    err_cnt        = 0;
    cyc            = 0;
    stall_cnt      = 0;
    for (int i = 0; i < NBINS; i++) begin
      bin_hits[i] = '0;
      bin_addr[i] = '0;
    end
    fill_stimulus();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while ((stim_q.size() != 0) || in_valid) @(negedge clk);
    while (top_bin_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
